@@ src/rsws_pkg.sv @@
// rsws_pkg: shared types and constants for the record sort with statistics block.
// Used by the interfaces, the sort cell, the divider and the top level.
`default_nettype none

package rsws_pkg;

  localparam int KEY_W           = 16;
  localparam int TAG_W           = 6;
  localparam int CNT_W           = 7;
  localparam int SUM_W           = 22;
  localparam int AVG_W           = 16;
  localparam int MAX_RECORDS_DEF = 64;

  // One stored record: sort key plus the tag carried along with it
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // Control broadcast to every cell of the sort chain
  typedef struct packed {
    logic ins;    // insert rec into its sorted place
    logic shift;  // move every record one cell towards cell 0
    rec_t rec;    // record being inserted
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/rsws_if.sv @@
// rsws_in_if / rsws_out_if: valid/ready channels for input records and sorted results.
// Depends on rsws_pkg for field widths.
`default_nettype none

interface rsws_in_if;
  import rsws_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] distance;
  logic [TAG_W-1:0] tag;
  logic             last;

  modport source (output valid, output distance, output tag, output last, input ready);
  modport sink   (input valid, input distance, input tag, input last, output ready);
endinterface

interface rsws_out_if;
  import rsws_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_distance;
  logic [TAG_W-1:0] sorted_tag;
  logic             end_of_batch;
  logic [TAG_W-1:0] min_tag;
  logic [KEY_W-1:0] min_distance;
  logic [TAG_W-1:0] max_tag;
  logic [KEY_W-1:0] max_distance;
  logic [CNT_W-1:0] record_count;
  logic [SUM_W-1:0] distance_sum;
  logic [AVG_W-1:0] distance_average;
  logic             overflow;

  modport source (output valid, output sorted_distance, output sorted_tag,
                  output end_of_batch, output min_tag, output min_distance,
                  output max_tag, output max_distance, output record_count,
                  output distance_sum, output distance_average, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_distance, input sorted_tag,
                  input end_of_batch, input min_tag, input min_distance,
                  input max_tag, input max_distance, input record_count,
                  input distance_sum, input distance_average, input overflow,
                  output ready);
endinterface

`default_nettype wire

@@ src/record_sort_with_stats_core.sv @@
// record_sort_with_stats_core: stable insertion sort of a record batch with statistics.
// Depends on rsws_pkg, rsws_in_if / rsws_out_if, rsws_cell and rsws_div.
//
// Usage:
//   in_rec carries records (distance key, tag, last). Records are taken one a
//   cycle while loading; each is inserted straight into its sorted place in a
//   chain of MAX_RECORDS cells.
//   A word with last = 1 closes the batch. Records beyond MAX_RECORDS are
//   dropped and reported through overflow on the final result.
//   out_res then gives one word per stored record, smallest key first, equal
//   keys in arrival order, one word a cycle while the receiver takes them.
//   The final word has end_of_batch set and carries min/max, count, sum and
//   the average. The average comes from a one-bit-per-cycle divider started
//   when the batch closes, so the final word waits until the divider has
//   finished, and any receiver stall holds the unloading further.
//   in_rec.ready is low while a batch is unloading. A stalled receiver holds
//   the output word and freezes the chain. Reset empties the batch; the
//   chain contents themselves are not cleared.
`default_nettype none

module record_sort_with_stats_core
  import rsws_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rsws_in_if.sink    in_rec,
  rsws_out_if.source out_res
);

  typedef enum logic {ST_LOAD, ST_UNLOAD} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;     // records in the chain
  logic [CNT_W-1:0] n_r, n_nxt;         // batch size while unloading
  logic [CNT_W-1:0] rem_r, rem_nxt;     // words still to unload
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             drop_r, drop_nxt;
  rec_t             min_r, min_nxt;

  logic             out_valid_r, out_valid_nxt;
  rec_t             out_rec_r, out_rec_nxt;
  logic             out_eob_r, out_eob_nxt;
  rec_t             out_min_r, out_min_nxt;
  rec_t             out_max_r, out_max_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic [AVG_W-1:0] out_avg_r, out_avg_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             in_acc, ins, close, pop, final_pop;
  logic [CNT_W-1:0] cnt_ins;
  logic [SUM_W-1:0] sum_ins;
  logic             div_busy;
  logic [SUM_W-1:0] div_quo;
  cell_ctl_t        ctl;
  rec_t             in_word;

  rec_t             cell_rec  [MAX_RECORDS];
  logic             cell_take [MAX_RECORDS];

  // Input side
  assign in_rec.ready   = (state_r == ST_LOAD);
  assign in_acc         = in_rec.valid && in_rec.ready;
  assign in_word.key    = in_rec.distance;
  assign in_word.tag    = in_rec.tag;
  assign ins            = in_acc && (cnt_r < CNT_W'(MAX_RECORDS));
  assign close          = in_acc && in_rec.last;
  assign cnt_ins        = ins ? cnt_r + 1'b1 : cnt_r;
  assign sum_ins        = ins ? sum_r + SUM_W'(in_rec.distance) : sum_r;

  // Unload one word when the output register frees up; the final word waits
  // for the average
  assign pop       = (state_r == ST_UNLOAD) && (!out_valid_r || out_res.ready) &&
                     ((rem_r != CNT_W'(1)) || !div_busy);
  assign final_pop = pop && (rem_r == CNT_W'(1));

  assign ctl.ins   = ins;
  assign ctl.shift = pop;
  assign ctl.rec   = in_word;

  // Sort chain: cell 0 holds the smallest key
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic occ;
    rec_t prev_rec;
    logic prev_take;
    rec_t next_rec;

    assign occ = (cnt_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_rec  = '0;
      assign prev_take = 1'b0;
    end else begin : g_mid
      assign prev_rec  = cell_rec[i-1];
      assign prev_take = cell_take[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_rec = '0;
    end else begin : g_body
      assign next_rec = cell_rec[i+1];
    end

    rsws_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .prev_rec  (prev_rec),
      .prev_take (prev_take),
      .next_rec  (next_rec),
      .rec       (cell_rec[i]),
      .take      (cell_take[i])
    );
  end

  // Batch average
  rsws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (close),
    .dividend (sum_ins),
    .divisor  (cnt_ins),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Batch control and output word
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    rem_nxt       = rem_r;
    sum_nxt       = sum_r;
    drop_nxt      = drop_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_rec_nxt   = out_rec_r;
    out_eob_nxt   = out_eob_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_cnt_nxt   = out_cnt_r;
    out_sum_nxt   = out_sum_r;
    out_avg_nxt   = out_avg_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          cnt_nxt  = cnt_ins;
          sum_nxt  = sum_ins;
          drop_nxt = drop_r || !ins;
          if (in_rec.last) begin
            state_nxt = ST_UNLOAD;
            n_nxt     = cnt_ins;
            rem_nxt   = cnt_ins;
          end
        end
      end
      ST_UNLOAD: begin
        if (pop) begin
          out_valid_nxt = 1'b1;
          out_rec_nxt   = cell_rec[0];
          out_eob_nxt   = final_pop;
          if (rem_r == n_r) begin
            min_nxt = cell_rec[0];
          end
          rem_nxt = rem_r - 1'b1;
          if (final_pop) begin
            out_min_nxt = (rem_r == n_r) ? cell_rec[0] : min_r;
            out_max_nxt = cell_rec[0];
            out_cnt_nxt = n_r;
            out_sum_nxt = sum_r;
            out_avg_nxt = div_quo[AVG_W-1:0];
            out_ovf_nxt = drop_r;
            state_nxt   = ST_LOAD;
            cnt_nxt     = '0;
            sum_nxt     = '0;
            drop_nxt    = 1'b0;
          end else begin
            out_min_nxt = '0;
            out_max_nxt = '0;
            out_cnt_nxt = '0;
            out_sum_nxt = '0;
            out_avg_nxt = '0;
            out_ovf_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      rem_r       <= '0;
      n_r         <= '0;
      sum_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      n_r         <= n_nxt;
      sum_r       <= sum_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    min_r     <= min_nxt;
    out_rec_r <= out_rec_nxt;
    out_eob_r <= out_eob_nxt;
    out_min_r <= out_min_nxt;
    out_max_r <= out_max_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_sum_r <= out_sum_nxt;
    out_avg_r <= out_avg_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // Output channel
  assign out_res.valid            = out_valid_r;
  assign out_res.sorted_distance  = out_rec_r.key;
  assign out_res.sorted_tag       = out_rec_r.tag;
  assign out_res.end_of_batch     = out_eob_r;
  assign out_res.min_tag          = out_min_r.tag;
  assign out_res.min_distance     = out_min_r.key;
  assign out_res.max_tag          = out_max_r.tag;
  assign out_res.max_distance     = out_max_r.key;
  assign out_res.record_count     = out_cnt_r;
  assign out_res.distance_sum     = out_sum_r;
  assign out_res.distance_average = out_avg_r;
  assign out_res.overflow         = out_ovf_r;

endmodule

`default_nettype wire

@@ src/rsws_cell.sv @@
// rsws_cell: one cell of the insertion sort chain, holding a single record.
// Depends on rsws_pkg (rec_t, cell_ctl_t).
`default_nettype none

module rsws_cell
  import rsws_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occ,        // this cell holds a live record
  input  wire rec_t      prev_rec,   // record of the cell nearer the head
  input  wire logic      prev_take,  // the cell nearer the head gives way too
  input  wire rec_t      next_rec,   // record of the cell nearer the tail
  output rec_t           rec,
  output logic           take
);

  rec_t rec_r;
  rec_t rec_nxt;

  // Give way when empty or holding a strictly larger key; equal keys stay
  // ahead of the newcomer, which keeps the sort stable.
  assign take = !occ || (rec_r.key > ctl.rec.key);

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.ins && take) begin
      rec_nxt = prev_take ? prev_rec : ctl.rec;
    end else if (ctl.shift) begin
      rec_nxt = next_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

`default_nettype wire

@@ src/rsws_div.sv @@
// rsws_div: restoring divider, one quotient bit per cycle, for the batch average.
// Depends on rsws_pkg (SUM_W, CNT_W).
`default_nettype none

module rsws_div
  import rsws_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  busy,
  output logic      [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W:0]    trial;
  logic              fits;

  // Bring down the next dividend bit and try the subtraction
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SUM_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      rem_nxt  = fits ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire
